// File: rtl/teq_pkg.sv
// Shared types and constants of the timed event queue.
package teq_pkg;

  // Fixed field widths of the ports
  localparam int unsigned FUNC_W         = 3;
  localparam int unsigned PORT_PAYLOAD_W = 32;
  localparam int unsigned DEADLINE_W     = 64;
  localparam int unsigned STATUS_W       = 2;

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_TAIL    = 3'd0,
    FN_PUSH_HEAD    = 3'd1,
    FN_POP_HEAD     = 3'd2,
    FN_TIMED_INSERT = 3'd3,
    FN_PEEK_HEAD    = 3'd4
  } func_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_HEAD,
    S_SCAN,
    S_SHIFT,
    S_TAIL
  } ctrl_state_t;

  // Read address select: logical slot pos or pos + 1
  typedef enum logic {
    RD_POS,
    RD_NEXT
  } rd_sel_t;

  // Write address select: logical slot pos, slot count, or one ahead of the head
  typedef enum logic [1:0] {
    WR_POS,
    WR_COUNT,
    WR_FRONT
  } wr_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    carry_take;
    logic    pos_inc;
    logic    count_inc;
    logic    count_dec;
    logic    head_adv;
    logic    resp_en;
    status_t resp_status;
    logic    resp_data;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    func_t func;
    logic  full;
    logic  empty;
    logic  last;
    logic  go_past;
  } dp_stat_t;

endpackage

// File: rtl/timed_event_queue.sv
// Top level of the timed event queue.
//
// Usage: present an operation on in_func with the entry fields and raise
// start; the beat is taken at a rising edge with start high and busy low.
// Operations: push tail, push head, pop head, timed insert, peek head.
// Every operation returns exactly one result beat, shown for one cycle with
// out_valid high; the receiver cannot stall and must take it then.
// Timing: busy stays high in dispatch alone for pushes, unused codes and
// any operation that reports empty or full, in dispatch and head for a pop
// or peek of a held entry, and for a timed insert among held entries in
// dispatch, the scan and shift walk and, when an entry is carried, the tail
// state. The result strobes in the first cycle busy is low again, and a new
// start may be taken in that same cycle. The insert walk visits one slot per
// cycle, set by the single read and single write port of the slot memory.
// Entries live in a ring buffer, so head pushes and pops do not move data.
// Reset (rst_n low, synchronous) empties the queue and cancels any work in
// flight; slot contents are not cleared and need no clearing pass.
module timed_event_queue #(
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [teq_pkg::FUNC_W-1:0]          in_func,
  input  logic [teq_pkg::PORT_PAYLOAD_W-1:0]  in_entry_payload,
  input  logic                                in_entry_is_timed,
  input  logic [teq_pkg::DEADLINE_W-1:0]      in_entry_deadline,
  output logic                                out_valid,
  output logic [teq_pkg::PORT_PAYLOAD_W-1:0]  out_payload,
  output logic                                out_is_timed,
  output logic [teq_pkg::DEADLINE_W-1:0]      out_deadline,
  output logic [teq_pkg::STATUS_W-1:0]        out_status,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]    out_occupancy
);

  teq_pkg::dp_cmd_t  cmd;
  teq_pkg::dp_stat_t stat;

  // Sequence each operation
  teq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Hold the slots and form the result beat
  teq_datapath #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_func           (in_func),
    .in_entry_payload  (in_entry_payload),
    .in_entry_is_timed (in_entry_is_timed),
    .in_entry_deadline (in_entry_deadline),
    .out_valid         (out_valid),
    .out_payload       (out_payload),
    .out_is_timed      (out_is_timed),
    .out_deadline      (out_deadline),
    .out_status        (out_status),
    .out_occupancy     (out_occupancy)
  );

endmodule

// File: rtl/teq_ctrl.sv
// Controller state machine of the timed event queue.
module teq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  teq_pkg::dp_stat_t  stat,
  output teq_pkg::dp_cmd_t   cmd
);

  teq_pkg::ctrl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= teq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    busy      = 1'b1;
    unique case (state_r)
      teq_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = teq_pkg::S_DISPATCH;
        end
      end

      teq_pkg::S_DISPATCH: begin
        state_nxt = teq_pkg::S_IDLE;
        unique case (stat.func)
          teq_pkg::FN_PUSH_TAIL: begin
            cmd.resp_en = 1'b1;
            if (stat.full) begin
              cmd.resp_status = teq_pkg::ST_FULL;
            end else begin
              cmd.wr_en     = 1'b1;
              cmd.wr_sel    = teq_pkg::WR_COUNT;
              cmd.count_inc = 1'b1;
            end
          end
          teq_pkg::FN_PUSH_HEAD: begin
            cmd.resp_en = 1'b1;
            if (stat.full) begin
              cmd.resp_status = teq_pkg::ST_FULL;
            end else begin
              cmd.wr_en     = 1'b1;
              cmd.wr_sel    = teq_pkg::WR_FRONT;
              cmd.count_inc = 1'b1;
            end
          end
          teq_pkg::FN_TIMED_INSERT: begin
            if (stat.full) begin
              cmd.resp_en     = 1'b1;
              cmd.resp_status = teq_pkg::ST_FULL;
            end else if (stat.empty) begin
              cmd.resp_en   = 1'b1;
              cmd.wr_en     = 1'b1;
              cmd.wr_sel    = teq_pkg::WR_COUNT;
              cmd.count_inc = 1'b1;
            end else begin
              // fetch the head to start the ordered walk
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = teq_pkg::RD_POS;
              state_nxt  = teq_pkg::S_SCAN;
            end
          end
          teq_pkg::FN_POP_HEAD, teq_pkg::FN_PEEK_HEAD: begin
            if (stat.empty) begin
              cmd.resp_en     = 1'b1;
              cmd.resp_status = teq_pkg::ST_EMPTY;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = teq_pkg::RD_POS;
              state_nxt  = teq_pkg::S_HEAD;
            end
          end
          default: begin
            cmd.resp_en = 1'b1;
          end
        endcase
      end

      teq_pkg::S_HEAD: begin
        // report the head beat, drop it on a pop
        cmd.resp_en   = 1'b1;
        cmd.resp_data = 1'b1;
        if (stat.func == teq_pkg::FN_POP_HEAD) begin
          cmd.head_adv  = 1'b1;
          cmd.count_dec = 1'b1;
        end
        state_nxt = teq_pkg::S_IDLE;
      end

      teq_pkg::S_SCAN: begin
        cmd.pos_inc = 1'b1;
        if (stat.go_past) begin
          // skip an earlier timed entry; past the last one, append at the tail
          if (stat.last) begin
            cmd.wr_en     = 1'b1;
            cmd.wr_sel    = teq_pkg::WR_COUNT;
            cmd.count_inc = 1'b1;
            cmd.resp_en   = 1'b1;
            state_nxt     = teq_pkg::S_IDLE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = teq_pkg::RD_NEXT;
          end
        end else begin
          // place the new entry here and carry the displaced one onward
          cmd.wr_en      = 1'b1;
          cmd.wr_sel     = teq_pkg::WR_POS;
          cmd.carry_take = 1'b1;
          if (stat.last) begin
            state_nxt = teq_pkg::S_TAIL;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = teq_pkg::RD_NEXT;
            state_nxt  = teq_pkg::S_SHIFT;
          end
        end
      end

      teq_pkg::S_SHIFT: begin
        // move each entry up one slot
        cmd.pos_inc    = 1'b1;
        cmd.wr_en      = 1'b1;
        cmd.wr_sel     = teq_pkg::WR_POS;
        cmd.carry_take = 1'b1;
        if (stat.last) begin
          state_nxt = teq_pkg::S_TAIL;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = teq_pkg::RD_NEXT;
        end
      end

      teq_pkg::S_TAIL: begin
        // append the last carried entry
        cmd.wr_en     = 1'b1;
        cmd.wr_sel    = teq_pkg::WR_COUNT;
        cmd.count_inc = 1'b1;
        cmd.resp_en   = 1'b1;
        state_nxt     = teq_pkg::S_IDLE;
      end

      default: begin
        state_nxt = teq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/teq_datapath.sv
// Datapath of the timed event queue: slot memory, ring pointers, carry and result registers.
module teq_datapath #(
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  teq_pkg::dp_cmd_t                      cmd,
  output teq_pkg::dp_stat_t                     stat,
  input  logic [teq_pkg::FUNC_W-1:0]            in_func,
  input  logic [teq_pkg::PORT_PAYLOAD_W-1:0]    in_entry_payload,
  input  logic                                  in_entry_is_timed,
  input  logic [teq_pkg::DEADLINE_W-1:0]        in_entry_deadline,
  output logic                                  out_valid,
  output logic [teq_pkg::PORT_PAYLOAD_W-1:0]    out_payload,
  output logic                                  out_is_timed,
  output logic [teq_pkg::DEADLINE_W-1:0]        out_deadline,
  output logic [teq_pkg::STATUS_W-1:0]          out_status,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]      out_occupancy
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic                           timed;
    logic [teq_pkg::DEADLINE_W-1:0] deadline;
    logic [PAYLOAD_BITS-1:0]        payload;
  } slot_t;

  slot_t             mem [QUEUE_DEPTH];
  slot_t             rd_data_r;
  slot_t             carry_r;
  teq_pkg::func_t    func_r;
  logic [AW-1:0]     head_r;
  logic [AW-1:0]     head_dec;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     pos_r, pos_inc;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic              out_valid_r;
  logic [teq_pkg::PORT_PAYLOAD_W-1:0] out_payload_r;
  logic                               out_is_timed_r;
  logic [teq_pkg::DEADLINE_W-1:0]     out_deadline_r;
  teq_pkg::status_t                   out_status_r;
  logic [CW-1:0]                      out_occupancy_r;

  // Map a logical offset from the head onto a physical slot of the ring
  function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                              input logic [CW-1:0] ofs);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(ofs);
    if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CW+1)'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  // Address and counter arithmetic
  always_comb begin
    pos_inc   = pos_r + CW'(1);
    head_dec  = (head_r == '0) ? AW'(QUEUE_DEPTH - 1) : head_r - AW'(1);
    count_nxt = count_r;
    if (cmd.count_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.count_dec) begin
      count_nxt = count_r - CW'(1);
    end
    rd_addr = ring_addr(head_r, (cmd.rd_sel == teq_pkg::RD_NEXT) ? pos_inc : pos_r);
    unique case (cmd.wr_sel)
      teq_pkg::WR_POS:   wr_addr = ring_addr(head_r, pos_r);
      teq_pkg::WR_COUNT: wr_addr = ring_addr(head_r, count_r);
      teq_pkg::WR_FRONT: wr_addr = head_dec;
      default:           wr_addr = ring_addr(head_r, pos_r);
    endcase
  end

  // Status toward the controller
  always_comb begin
    stat.func    = func_r;
    stat.full    = (count_r == CW'(QUEUE_DEPTH));
    stat.empty   = (count_r == '0);
    stat.last    = (pos_inc == count_r);
    stat.go_past = rd_data_r.timed && (carry_r.deadline > rd_data_r.deadline);
  end

  // Slot memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= carry_r;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Hold the item and the carried entry, advance the walk position
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r           <= teq_pkg::func_t'(in_func);
      carry_r.payload  <= PAYLOAD_BITS'(in_entry_payload);
      carry_r.deadline <= in_entry_deadline;
      carry_r.timed    <= in_entry_is_timed
                          || (in_func == teq_pkg::FN_TIMED_INSERT);
      pos_r            <= '0;
    end else begin
      if (cmd.carry_take) begin
        carry_r <= rd_data_r;
      end
      if (cmd.pos_inc) begin
        pos_r <= pos_inc;
      end
    end
  end

  // Ring pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (cmd.wr_en && (cmd.wr_sel == teq_pkg::WR_FRONT)) begin
        head_r <= head_dec;
      end else if (cmd.head_adv) begin
        head_r <= ring_addr(head_r, CW'(1));
      end
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.resp_en;
    end
  end

  // Result beat
  always_ff @(posedge clk) begin
    if (cmd.resp_en) begin
      out_status_r    <= cmd.resp_status;
      out_occupancy_r <= count_nxt;
      if (cmd.resp_data) begin
        out_payload_r  <= teq_pkg::PORT_PAYLOAD_W'(rd_data_r.payload);
        out_is_timed_r <= rd_data_r.timed;
        out_deadline_r <= rd_data_r.deadline;
      end else begin
        out_payload_r  <= '0;
        out_is_timed_r <= 1'b0;
        out_deadline_r <= '0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_payload   = out_payload_r;
  assign out_is_timed  = out_is_timed_r;
  assign out_deadline  = out_deadline_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occupancy_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= AW'(QUEUE_DEPTH - 1))
    else $error("head pointer outside the ring");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == teq_pkg::ST_FULL)
      |-> (out_occupancy_r == CW'(QUEUE_DEPTH)))
    else $error("full status with free slots");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == teq_pkg::ST_EMPTY) |-> (out_occupancy_r == '0))
    else $error("empty status with entries held");
`endif

endmodule
